// ===== rtl/mf_pkg.sv =====
// Shared types, sizes, register indexes and compare helpers for the 3x3 median filter.
// Depends on nothing; mf_col_cell and median_filter_3x3 import it.
package mf_pkg;

   localparam int PIX_W      = 8;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int COORD_W    = 11;
   localparam int CFG_W      = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int MIN_DIM    = 3;

   typedef logic [PIX_W-1:0]   pix_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CFG_W-1:0]   cfg_type;
   typedef logic [ADDR_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]   row_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = CSR_IDX_W'(0),
      CSR_IMAGE_HEIGHT = CSR_IDX_W'(1)
   } csr_idx_type;

   localparam cfg_type WIDTH_RESET  = CFG_W'(640);
   localparam cfg_type HEIGHT_RESET = CFG_W'(480);

   typedef struct packed {
      pix_type lo;
      pix_type md;
      pix_type hi;
   } column_type;

   // Last valid index of a dimension after saturating it to MIN_DIM..lim.
   function automatic cfg_type dim_last(cfg_type v, int lim);
      cfg_type r;
      begin
         if (int'(v) < MIN_DIM) begin
            r = CFG_W'(MIN_DIM - 1);
         end else if (int'(v) > lim) begin
            r = CFG_W'(lim - 1);
         end else begin
            r = v - 1'b1;
         end
         return r;
      end
   endfunction

   function automatic column_type sort3(pix_type a, pix_type b, pix_type c);
      pix_type    x0;
      pix_type    x1;
      pix_type    x2;
      pix_type    t;
      column_type r;
      begin
         x0 = a;
         x1 = b;
         x2 = c;
         if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
         end
         if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
         end
         if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
         end
         r.lo = x0;
         r.md = x1;
         r.hi = x2;
         return r;
      end
   endfunction

   function automatic pix_type max3(pix_type a, pix_type b, pix_type c);
      pix_type m;
      begin
         m = (a > b) ? a : b;
         return (m > c) ? m : c;
      end
   endfunction

   function automatic pix_type min3(pix_type a, pix_type b, pix_type c);
      pix_type m;
      begin
         m = (a < b) ? a : b;
         return (m < c) ? m : c;
      end
   endfunction

   function automatic pix_type med3(pix_type a, pix_type b, pix_type c);
      column_type s;
      begin
         s = sort3(a, b, c);
         return s.md;
      end
   endfunction

endpackage

// ===== rtl/mf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; the filter uses it for its line buffers.
module mf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mf_col_cell.sv =====
// One column cell of the 3x3 window: sorts the column it receives and holds it.
// Depends on mf_pkg.
module mf_col_cell
   import mf_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  column_type col_in,
   output column_type col_out
);

   column_type col_ff;
   column_type col_in_sorted;

   // A column handed on from a neighbor cell is already sorted, so sorting it again keeps it.
   assign col_in_sorted = sort3(col_in.lo, col_in.md, col_in.hi);

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in_sorted;
      end
   end

   assign col_out = col_ff;

endmodule

// ===== rtl/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter with its configuration registers.
// Depends on mf_pkg, mf_ram and mf_col_cell.
//
//   Channel  Direction  Payload                                      Beat when
//   req_     in         pixel_value                                  req_valid & req_ready
//   rsp_     out        median_value, center_col, center_row, last   rsp_valid & rsp_ready
//   csr_     in         index, data (image_width, image_height)      csr_valid & csr_ready
//
// One pixel is taken every cycle while the result channel does not stall; the valid flag of the
// pixel which completes a window passes through s1, s2 and s3 into rsp_valid.
// The pipeline runs line buffer read, column sort into the window cells, row compare, and median.
// Any stall of the result channel holds the whole pipeline and drops req_ready in the same cycle.
// Reset is synchronous; it restores the 640 x 480 geometry and empties the pipeline.
// A write to image_width or image_height restarts the frame; the line buffers and window keep their contents.
module median_filter_3x3
   import mf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_median_value,
   output logic [COORD_W-1:0]   rsp_center_col,
   output logic [COORD_W-1:0]   rsp_center_row,
   output logic                 rsp_frame_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   logic advance;
   logic accept;
   logic restart;

   col_type w_last_ff;
   col_type w_last_in;
   row_type h_last_ff;
   row_type h_last_in;
   col_type col_ff;
   col_type col_in;
   row_type row_ff;
   row_type row_in;

   logic      s1_valid_ff;
   pix_type   s1_pix_ff;
   col_type   s1_col_ff;
   row_type   s1_row_ff;
   logic      s1_emit_ff;
   logic      s1_last_ff;

   logic      s2_valid_ff;
   coord_type s2_col_ff;
   coord_type s2_row_ff;
   logic      s2_last_ff;

   logic      s3_valid_ff;
   pix_type   s3_lo_ff;
   pix_type   s3_md_ff;
   pix_type   s3_hi_ff;
   coord_type s3_col_ff;
   coord_type s3_row_ff;
   logic      s3_last_ff;

   logic      rsp_valid_ff;
   pix_type   rsp_median_ff;
   coord_type rsp_col_ff;
   coord_type rsp_row_ff;
   logic      rsp_last_ff;

   pix_type    top_pix;
   pix_type    mid_pix;
   logic       shift_en;
   column_type new_col;
   column_type cell_q [3];

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign csr_ready = 1'b1;
   assign shift_en  = advance && s1_valid_ff;

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               w_last_in = ADDR_W'(dim_last(csr_data, MAX_WIDTH));
               restart   = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               h_last_in = ROW_W'(dim_last(csr_data, MAX_HEIGHT));
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == w_last_ff) begin
            col_in = '0;
            row_in = (row_ff == h_last_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff    <= ADDR_W'(dim_last(WIDTH_RESET, MAX_WIDTH));
         h_last_ff    <= ROW_W'(dim_last(HEIGHT_RESET, MAX_HEIGHT));
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (advance) begin
            s1_valid_ff  <= req_valid;
            s2_valid_ff  <= s1_valid_ff && s1_emit_ff;
            s3_valid_ff  <= s2_valid_ff;
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pix_ff  <= req_pixel_value;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_emit_ff <= (col_ff >= ADDR_W'(2)) && (row_ff >= ROW_W'(2));
         s1_last_ff <= (col_ff == w_last_ff) && (row_ff == h_last_ff);

         s2_col_ff  <= COORD_W'(s1_col_ff - 1'b1);
         s2_row_ff  <= COORD_W'(s1_row_ff - 1'b1);
         s2_last_ff <= s1_last_ff;

         s3_lo_ff   <= max3(cell_q[0].lo, cell_q[1].lo, cell_q[2].lo);
         s3_md_ff   <= med3(cell_q[0].md, cell_q[1].md, cell_q[2].md);
         s3_hi_ff   <= min3(cell_q[0].hi, cell_q[1].hi, cell_q[2].hi);
         s3_col_ff  <= s2_col_ff;
         s3_row_ff  <= s2_row_ff;
         s3_last_ff <= s2_last_ff;

         rsp_median_ff <= med3(s3_lo_ff, s3_md_ff, s3_hi_ff);
         rsp_col_ff    <= s3_col_ff;
         rsp_row_ff    <= s3_row_ff;
         rsp_last_ff   <= s3_last_ff;
      end
   end

   // Line buffer a holds the previous row, line buffer b the row before it.
   mf_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_a (
      .clock  (clock),
      .wr_en  (shift_en),
      .wr_addr(s1_col_ff),
      .wr_data(s1_pix_ff),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(mid_pix)
   );

   mf_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_b (
      .clock  (clock),
      .wr_en  (shift_en),
      .wr_addr(s1_col_ff),
      .wr_data(mid_pix),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(top_pix)
   );

   assign new_col.lo = top_pix;
   assign new_col.md = mid_pix;
   assign new_col.hi = s1_pix_ff;

   for (genvar k = 0; k < 3; k++) begin : g_cell
      if (k == 0) begin : g_head
         mf_col_cell u_cell (
            .clock   (clock),
            .shift_en(shift_en),
            .col_in  (new_col),
            .col_out (cell_q[k])
         );
      end else begin : g_tail
         mf_col_cell u_cell (
            .clock   (clock),
            .shift_en(shift_en),
            .col_in  (cell_q[k-1]),
            .col_out (cell_q[k])
         );
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_median_ff;
   assign rsp_center_col   = rsp_col_ff;
   assign rsp_center_row   = rsp_row_ff;
   assign rsp_frame_last   = rsp_last_ff;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last_ff)
      else $error("column counter beyond the row width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last_ff)
      else $error("row counter beyond the frame height");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("first stage lost its beat during a stall");

   a_cells_sorted: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> cell_q[0].lo <= cell_q[0].md && cell_q[0].md <= cell_q[0].hi
                   && cell_q[2].lo <= cell_q[2].md && cell_q[2].md <= cell_q[2].hi)
      else $error("window column not sorted");

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_col != '0 && rsp_center_row != '0)
      else $error("result for a border pixel");

endmodule
